// ----- rtl/core/i2cdw_pkg.sv -----
// types and constants shared by the i2c display write sequencer
`default_nettype none

package i2cdw_pkg;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_COMMAND = 2'd1;
    localparam logic [1:0] CMD_DATA    = 2'd2;

    localparam logic [7:0] CTRL_CMD  = 8'h00;
    localparam logic [7:0] CTRL_DATA = 8'h40;

    localparam logic [7:0]  ADDRESS_RESET = 8'h78;
    localparam logic [15:0] TICKS_RESET   = 16'd1;

    localparam logic REG_ADDRESS_BYTE   = 1'b0;
    localparam logic REG_TICKS_PER_UNIT = 1'b1;

    localparam int WAIT_W = 18;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ST_SDA1 = 4'd1,
        PH_ST_SCL1 = 4'd2,
        PH_ST_SDA0 = 4'd3,
        PH_BIT_LO  = 4'd4,
        PH_BIT_HI  = 4'd5,
        PH_ACK_LO  = 4'd6,
        PH_ACK_REL = 4'd7,
        PH_ACK_HI  = 4'd8,
        PH_ACK_END = 4'd9,
        PH_SP_SDA0 = 4'd10,
        PH_SP_SCL1 = 4'd11
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [1:0]          byte_index;
        logic [3:0]          bit_count;
        logic [7:0]          shift_byte;
        logic [7:0]          payload_hold;
        logic                is_data;
        logic [WAIT_W-1:0]   wait_count;
        logic                scl_level;
        logic                sda_level;
    } t_state;

    typedef struct packed {
        logic done_res;
        logic rejected;
        logic busy_res;
        logic sda;
        logic scl;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/i2cdw_step.sv -----
// next-state and result logic for one tick of the bus sequencer
`default_nettype none

module i2cdw_step
    import i2cdw_pkg::*;
(
    input  var t_state      i_state,
    input  wire [1:0]       i_cmd,
    input  wire [7:0]       i_payload,
    input  wire [7:0]       i_address_byte,
    input  wire [15:0]      i_ticks_per_unit,
    output var t_state      o_state,
    output var t_result     o_result
);

    logic [15:0]       ticks;
    logic [WAIT_W-1:0] unit1;
    logic [WAIT_W-1:0] unit3;
    logic              request;
    logic [WAIT_W-1:0] wait_dec;
    logic [7:0]        load_val;
    logic [1:0]        next_index;
    logic [3:0]        next_bits;
    logic [7:0]        shifted;
    logic              done;

    assign ticks   = (i_ticks_per_unit == 16'd0) ? 16'd1 : i_ticks_per_unit;
    assign unit1   = {2'b00, ticks};
    assign unit3   = unit1 + {1'b0, ticks, 1'b0};
    assign request = (i_cmd == CMD_COMMAND) || (i_cmd == CMD_DATA);
    assign wait_dec = (i_state.wait_count != '0) ? i_state.wait_count - 1'b1
                                                 : i_state.wait_count;
    assign next_index = i_state.byte_index + 2'd1;
    assign next_bits  = i_state.bit_count + 4'd1;
    assign shifted    = {i_state.shift_byte[6:0], 1'b0};

    // byte that goes out at the next load
    always_comb begin
        case (i_state.phase)
            PH_ST_SDA0: load_val = i_address_byte;
            default: begin
                if (next_index == 2'd1) begin
                    load_val = i_state.is_data ? CTRL_DATA : CTRL_CMD;
                end else begin
                    load_val = i_state.payload_hold;
                end
            end
        endcase
    end

    always_comb begin
        o_state = i_state;
        done    = 1'b0;
        if (i_state.phase == PH_IDLE) begin
            if (request) begin
                o_state.is_data      = (i_cmd == CMD_DATA);
                o_state.payload_hold = i_payload;
                o_state.byte_index   = 2'd0;
                o_state.bit_count    = 4'd0;
                o_state.phase        = PH_ST_SDA1;
                o_state.sda_level    = 1'b1;
                o_state.wait_count   = unit1;
            end
        end else if (wait_dec != '0) begin
            o_state.wait_count = wait_dec;
        end else begin
            o_state.wait_count = unit1;
            case (i_state.phase)
                PH_ST_SDA1: begin
                    o_state.phase     = PH_ST_SCL1;
                    o_state.scl_level = 1'b1;
                end
                PH_ST_SCL1: begin
                    o_state.phase      = PH_ST_SDA0;
                    o_state.sda_level  = 1'b0;
                    o_state.wait_count = unit3;
                end
                PH_ST_SDA0: begin
                    o_state.byte_index = 2'd0;
                    o_state.shift_byte = load_val;
                    o_state.bit_count  = 4'd0;
                    o_state.phase      = PH_BIT_LO;
                    o_state.scl_level  = 1'b0;
                    o_state.sda_level  = load_val[7];
                end
                PH_BIT_LO: begin
                    o_state.phase     = PH_BIT_HI;
                    o_state.scl_level = 1'b1;
                end
                PH_BIT_HI: begin
                    o_state.bit_count  = next_bits;
                    o_state.shift_byte = shifted;
                    o_state.scl_level  = 1'b0;
                    if (next_bits >= 4'd8) begin
                        o_state.phase = PH_ACK_LO;
                    end else begin
                        o_state.phase     = PH_BIT_LO;
                        o_state.sda_level = shifted[7];
                    end
                end
                PH_ACK_LO: begin
                    o_state.phase     = PH_ACK_REL;
                    o_state.sda_level = 1'b1;
                end
                PH_ACK_REL: begin
                    o_state.phase     = PH_ACK_HI;
                    o_state.scl_level = 1'b1;
                end
                PH_ACK_HI: begin
                    o_state.phase     = PH_ACK_END;
                    o_state.scl_level = 1'b0;
                end
                PH_ACK_END: begin
                    o_state.byte_index = next_index;
                    if (next_index >= 2'd3) begin
                        o_state.phase     = PH_SP_SDA0;
                        o_state.sda_level = 1'b0;
                    end else begin
                        o_state.shift_byte = load_val;
                        o_state.bit_count  = 4'd0;
                        o_state.phase      = PH_BIT_LO;
                        o_state.scl_level  = 1'b0;
                        o_state.sda_level  = load_val[7];
                    end
                end
                PH_SP_SDA0: begin
                    o_state.phase      = PH_SP_SCL1;
                    o_state.scl_level  = 1'b1;
                    o_state.wait_count = unit3;
                end
                default: begin
                    // stop completes, also recovers from unused phase codes
                    o_state.phase      = PH_IDLE;
                    o_state.sda_level  = 1'b1;
                    o_state.wait_count = '0;
                    done               = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_result.scl      = o_state.scl_level;
        o_result.sda      = o_state.sda_level;
        o_result.busy_res = (o_state.phase != PH_IDLE);
        o_result.rejected = (i_state.phase != PH_IDLE) && request;
        o_result.done_res = done;
    end

endmodule

`default_nettype wire

// ----- rtl/core/i2c_display_write_sequencer_core.sv -----
// write-only i2c master sequencer for a display controller, one tick per item
//
// usage: each transaction on the s_axis channel is one time tick. tuser carries
// cmd (0 tick only, 1 command write, 2 data write, 3 tick only) and tdata the
// payload byte. on an idle tick a request runs start, address byte, control
// byte, payload byte and stop; a request while busy is dropped and flagged.
// every input transaction yields exactly one m_axis transaction with the pin
// levels scl and sda after that tick and the busy, rejected and done flags.
// the result of a tick is registered and on m_axis in the cycle after acceptance.
// throughput: one tick per cycle while results are taken, set by the single
// output register; the next state is computed combinationally from r_state.
// when the receiver stalls, the result is held and s_axis_tready stays low
// until it is taken, so no tick is lost. reset puts the bus lines high,
// the sequencer idle, and restores address_byte 0x78 and ticks_per_unit 1.
// the apb port writes address_byte at 0x0 and ticks_per_unit at 0x4; write
// it only while the sequencer is idle.
`default_nettype none

module i2c_display_write_sequencer_core
    import i2cdw_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [7:0]  s_axis_tdata,   // [7:0] payload
    input  wire [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [0] scl [1] sda [2] busy_res [3] rejected
                                       // [4] done_res [7:5] zero
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire [2:0]  paddr,
    input  wire [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);

    t_state      r_state;
    t_state      n_state;
    t_result     n_result;
    t_result     r_result;
    logic        r_out_valid;
    logic [7:0]  r_address_byte;
    logic [15:0] r_ticks_per_unit;
    logic        in_accept;
    logic        cfg_write;

    assign pready        = 1'b1;
    assign cfg_write     = psel && penable && pwrite;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        case (paddr[2])
            REG_ADDRESS_BYTE: prdata = {24'd0, r_address_byte};
            default:          prdata = {16'd0, r_ticks_per_unit};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_byte   <= ADDRESS_RESET;
            r_ticks_per_unit <= TICKS_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_ADDRESS_BYTE: r_address_byte <= pwdata[7:0];
                default:          r_ticks_per_unit <= pwdata[15:0];
            endcase
        end
    end

    i2cdw_step u_step (
        .i_state          (r_state),
        .i_cmd            (s_axis_tuser),
        .i_payload        (s_axis_tdata),
        .i_address_byte   (r_address_byte),
        .i_ticks_per_unit (r_ticks_per_unit),
        .o_state          (n_state),
        .o_result         (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_IDLE;
            r_state.byte_index   <= 2'd0;
            r_state.bit_count    <= 4'd0;
            r_state.shift_byte   <= 8'd0;
            r_state.payload_hold <= 8'd0;
            r_state.is_data      <= 1'b0;
            r_state.wait_count   <= '0;
            r_state.scl_level    <= 1'b1;
            r_state.sda_level    <= 1'b1;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_result};

    // a finished stop never reports busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[2]))
        else $error("done and busy reported together");

    // an idle sequencer never holds a pending delay
    a_idle_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_IDLE) |-> (r_state.wait_count == '0))
        else $error("delay count left while idle");

    // a plain tick on an idle sequencer keeps it idle
    a_idle_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_state.phase == PH_IDLE && s_axis_tuser != CMD_COMMAND
         && s_axis_tuser != CMD_DATA) |=> (r_state.phase == PH_IDLE))
        else $error("sequencer left idle without a request");

    // every accepted tick produces a result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> m_axis_tvalid)
        else $error("accepted tick produced no result");

endmodule

`default_nettype wire

// ----- sim/tb_i2c_display_write_sequencer_core.sv -----
// testbench for the i2c display write sequencer: stream ticks in, bus levels checked per tick
`timescale 1ns / 1ps

module tb_i2c_display_write_sequencer_core;
    import i2cdw_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [2:0] ADDR_ADDRESS_BYTE   = {REG_ADDRESS_BYTE, 2'b00};
    localparam logic [2:0] ADDR_TICKS_PER_UNIT = {REG_TICKS_PER_UNIT, 2'b00};
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] payload
    logic [1:0]  s_axis_tuser = '0;    // [1:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [0] scl [1] sda [2] busy_res [3] rejected [4] done_res
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    i2c_display_write_sequencer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // sequencer mirror: configuration and state
    logic [7:0]  cfg_address;
    logic [15:0] cfg_ticks;
    t_phase      ph;
    logic [1:0]  byte_sel;
    logic [3:0]  bits_sent;
    logic [7:0]  shifter;
    logic [7:0]  held_payload;
    logic        data_mode;
    logic [WAIT_W-1:0] hold_left;
    logic        scl_q;
    logic        sda_q;

    t_result     expected_levels[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatch_count = 0;
    int          ticks_sent = 0;
    int          transfers_done = 0;
    int          requests_dropped = 0;
    int unsigned cycle_count = 0;

    function automatic void hold_units(input int units);
        logic [15:0] unit_ticks;
        unit_ticks = (cfg_ticks == 16'd0) ? 16'd1 : cfg_ticks;
        hold_left = WAIT_W'(units * unit_ticks);
    endfunction

    function automatic void enter_bit_low();
        ph = PH_BIT_LO;
        scl_q = 1'b0;
        sda_q = shifter[7];
        hold_units(1);
    endfunction

    function automatic void load_next_byte();
        if (byte_sel == 2'd0)
            shifter = cfg_address;
        else if (byte_sel == 2'd1)
            shifter = data_mode ? CTRL_DATA : CTRL_CMD;
        else
            shifter = held_payload;
        bits_sent = 4'd0;
        enter_bit_low();
    endfunction

    // steps the pin timeline; returns 1 when the stop condition completes
    function automatic logic advance_step();
        case (ph)
            PH_ST_SDA1: begin
                ph = PH_ST_SCL1; scl_q = 1'b1; hold_units(1);
            end
            PH_ST_SCL1: begin
                ph = PH_ST_SDA0; sda_q = 1'b0; hold_units(3);
            end
            PH_ST_SDA0: begin
                byte_sel = 2'd0;
                load_next_byte();
            end
            PH_BIT_LO: begin
                ph = PH_BIT_HI; scl_q = 1'b1; hold_units(1);
            end
            PH_BIT_HI: begin
                bits_sent = bits_sent + 4'd1;
                shifter = shifter << 1;
                if (bits_sent >= 4'd8) begin
                    ph = PH_ACK_LO; scl_q = 1'b0; hold_units(1);
                end else begin
                    enter_bit_low();
                end
            end
            PH_ACK_LO: begin
                ph = PH_ACK_REL; sda_q = 1'b1; hold_units(1);
            end
            PH_ACK_REL: begin
                ph = PH_ACK_HI; scl_q = 1'b1; hold_units(1);
            end
            PH_ACK_HI: begin
                ph = PH_ACK_END; scl_q = 1'b0; hold_units(1);
            end
            PH_ACK_END: begin
                byte_sel = byte_sel + 2'd1;
                if (byte_sel >= 2'd3) begin
                    ph = PH_SP_SDA0; sda_q = 1'b0; hold_units(1);
                end else begin
                    load_next_byte();
                end
            end
            PH_SP_SDA0: begin
                ph = PH_SP_SCL1; scl_q = 1'b1; hold_units(3);
            end
            default: begin
                ph = PH_IDLE; sda_q = 1'b1; hold_left = '0;
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic t_result sequence_tick(input logic [1:0] cmd, input logic [7:0] payload);
        t_result r;
        logic    req;
        r = '0;
        req = (cmd == CMD_COMMAND) || (cmd == CMD_DATA);
        if (ph == PH_IDLE) begin
            if (req) begin
                data_mode = (cmd == CMD_DATA);
                held_payload = payload;
                byte_sel = 2'd0;
                bits_sent = 4'd0;
                ph = PH_ST_SDA1;
                sda_q = 1'b1;
                hold_units(1);
            end
        end else begin
            r.rejected = req;
            if (hold_left != '0)
                hold_left = hold_left - 1'b1;
            if (hold_left == '0)
                r.done_res = advance_step();
        end
        r.scl = scl_q;
        r.sda = sda_q;
        r.busy_res = (ph != PH_IDLE);
        return r;
    endfunction

    function automatic logic stop_completes_next();
        return (ph == PH_SP_SCL1) && (hold_left <= 1);
    endfunction

    task automatic send_tick(input logic [1:0] cmd, input logic [7:0] payload);
        t_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= payload;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        r = sequence_tick(cmd, payload);
        expected_levels.push_back(r);
        ticks_sent++;
        transfers_done += r.done_res;
        requests_dropped += r.rejected;
    endtask

    // ticks until the mirror is idle, optionally with a request on the stop tick
    task automatic finish_transfer(input logic poke_at_stop);
        while (ph != PH_IDLE) begin
            if (poke_at_stop && stop_completes_next())
                send_tick(CMD_DATA, 8'($urandom_range(255)));
            else
                send_tick(CMD_TICK, 8'($urandom_range(255)));
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_register(input logic [2:0] addr, input logic [31:0] want);
        logic [31:0] got;
        apb_access(1'b0, addr, '0, got);
        if (got !== want) begin
            $error("register %0h expected %0h got %0h", addr, want, got);
            mismatch_count++;
        end
    endtask

    task automatic set_register(input logic [2:0] addr, input logic [15:0] value);
        logic [31:0] unused;
        apb_access(1'b1, addr, {16'd0, value}, unused);
        if (addr == ADDR_ADDRESS_BYTE) begin
            cfg_address = value[7:0];
            check_register(addr, {24'd0, value[7:0]});
        end else begin
            cfg_ticks = value;
            check_register(addr, {16'd0, value});
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s expected %0h got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // result checker and receiver stalls
    t_result want_levels;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_levels.size() == 0) begin
                $error("result transaction %0h with nothing expected", m_axis_tdata);
                mismatch_count++;
            end else begin
                want_levels = expected_levels.pop_front();
                check_field("scl", 8'(want_levels.scl), 8'(m_axis_tdata[0]));
                check_field("sda", 8'(want_levels.sda), 8'(m_axis_tdata[1]));
                check_field("busy_res", 8'(want_levels.busy_res), 8'(m_axis_tdata[2]));
                check_field("rejected", 8'(want_levels.rejected), 8'(m_axis_tdata[3]));
                check_field("done_res", 8'(want_levels.done_res), 8'(m_axis_tdata[4]));
                check_field("pad", 8'd0, 8'(m_axis_tdata[7:5]));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic test_register_access();
        check_register(ADDR_ADDRESS_BYTE, {24'd0, ADDRESS_RESET});
        check_register(ADDR_TICKS_PER_UNIT, {16'd0, TICKS_RESET});
        set_register(ADDR_ADDRESS_BYTE, 16'h00FF);
        set_register(ADDR_TICKS_PER_UNIT, 16'hFFFF);
    endtask

    task automatic test_directed_sequences();
        // zero unit length behaves as one tick
        set_register(ADDR_TICKS_PER_UNIT, 16'd0);
        set_register(ADDR_ADDRESS_BYTE, 16'h00FF);
        send_tick(CMD_UNUSED, 8'hFF);
        send_tick(CMD_TICK, 8'h00);
        send_tick(CMD_COMMAND, 8'h00);
        send_tick(CMD_DATA, 8'h5A);     // dropped while busy
        send_tick(CMD_UNUSED, 8'h33);
        send_tick(CMD_COMMAND, 8'hC3);  // dropped while busy
        finish_transfer(1'b1);          // request lands on the stop tick
        settle();

        set_register(ADDR_ADDRESS_BYTE, 16'h0000);
        set_register(ADDR_TICKS_PER_UNIT, 16'd3);
        send_tick(CMD_DATA, 8'hFF);
        send_tick(CMD_UNUSED, 8'h00);
        finish_transfer(1'b0);
        send_tick(CMD_COMMAND, 8'h81);
        finish_transfer(1'b1);
        settle();

        set_register(ADDR_ADDRESS_BYTE, 16'h0078);
        set_register(ADDR_TICKS_PER_UNIT, 16'd1);
        send_tick(CMD_DATA, 8'hA5);
        finish_transfer(1'b0);
        settle();
    endtask

    task automatic test_random_traffic(input int n_items, input int s_idle, input int r_idle,
                                       input logic [15:0] unit_ticks);
        int         roll;
        logic [1:0] cmd;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        set_register(ADDR_ADDRESS_BYTE, 16'($urandom_range(255)));
        set_register(ADDR_TICKS_PER_UNIT, unit_ticks);
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(99);
            if (ph == PH_IDLE)
                cmd = (roll < 70) ? ($urandom_range(1) ? CMD_DATA : CMD_COMMAND)
                    : (roll < 85) ? CMD_TICK : CMD_UNUSED;
            else if (stop_completes_next() && roll < 50)
                cmd = $urandom_range(1) ? CMD_DATA : CMD_COMMAND;
            else
                cmd = (roll < 4) ? CMD_DATA : (roll < 8) ? CMD_COMMAND
                    : (roll < 12) ? CMD_UNUSED : CMD_TICK;
            send_tick(cmd, 8'($urandom_range(255)));
        end
        finish_transfer(1'b0);
        settle();
    endtask

    // longest unit: the request is taken and held in the first start step
    task automatic test_long_unit();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_register(ADDR_ADDRESS_BYTE, 16'($urandom_range(255)));
        set_register(ADDR_TICKS_PER_UNIT, 16'hFFFF);
        send_tick(CMD_DATA, 8'($urandom_range(255)));
        for (int i = 0; i < 20; i++) begin
            if (i == 10)
                send_tick(CMD_COMMAND, 8'($urandom_range(255)));
            else
                send_tick(CMD_TICK, 8'($urandom_range(255)));
        end
    endtask

    initial begin
        cfg_address = ADDRESS_RESET;
        cfg_ticks = TICKS_RESET;
        ph = PH_IDLE;
        byte_sel = '0;
        bits_sent = '0;
        shifter = '0;
        held_payload = '0;
        data_mode = 1'b0;
        hold_left = '0;
        scl_q = 1'b1;
        sda_q = 1'b1;
        send_idle_pct = 21;
        recv_idle_pct = 67;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_directed_sequences();
        test_random_traffic(70, 21, 67, 16'd1);
        test_random_traffic(70, 67, 21, 16'd2);
        test_random_traffic(70, 0, 0, 16'd0);
        test_long_unit();

        s_axis_tvalid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("ran %0d ticks: %0d transfers completed, %0d requests dropped while busy",
                 ticks_sent, transfers_done, requests_dropped);
        $display("unit lengths 0 to 65535 and address bytes 0x00 to 0xff, stalls on both sides");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
